// ----- rtl/pfb_pkg.sv -----
package pfb_pkg;

	localparam int COLUMNS = 128;
	localparam int PAGES   = 8;
	localparam int ROWS    = PAGES * 8;
	localparam int DEPTH   = COLUMNS * PAGES;
	localparam int ADDR_W  = $clog2(DEPTH);

	localparam logic [2:0] CMD_PLOT        = 3'd0;
	localparam logic [2:0] CMD_CLEAR       = 3'd1;
	localparam logic [2:0] CMD_READ        = 3'd2;
	localparam logic [2:0] CMD_GLYPH_START = 3'd3;
	localparam logic [2:0] CMD_GLYPH_BYTE  = 3'd4;

	localparam logic [7:0] GLYPH_H12 = 8'd12;
	localparam logic [7:0] GLYPH_H16 = 8'd16;
	localparam logic [7:0] GLYPH_H24 = 8'd24;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] x;
		logic [7:0] y;
		logic       pixel_on;
		logic [7:0] glyph_height;
		logic [7:0] data_byte;
	} req_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic       status;
	} rsp_t;

	// store write port
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} wr_t;

	// byte address of (column, page)
	function automatic logic [ADDR_W-1:0] store_addr(input logic [7:0] col,
		input logic [7:0] page);
		logic [15:0] full;
		full = 16'(col) * 16'(PAGES) + 16'(page);
		return full[ADDR_W-1:0];
	endfunction

endpackage

// ----- rtl/pfb_store.sv -----
module pfb_store import pfb_pkg::*; (
	input  logic              clk,
	input  wr_t               wr,
	input  logic [ADDR_W-1:0] raddr,
	output logic [7:0]        rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/page_framebuffer_plot_and_glyph_blit.sv -----
// Monochrome page frame store: COLUMNS columns by PAGES pages of bytes.
// Pixel (x, y) lives in page PAGES-1 - y/8 of column x, bit 7 - y%8.
// req channel (valid/ready, one beat per command): plot, clear, read byte,
// glyph start, glyph byte. rsp channel (valid/ready): exactly one beat per
// command, carrying read_byte (zero unless a good read) and status.
// One command is worked at a time; req_ready is high only while idle.
// Work per command before the result reaches the rsp register:
//   glyph start, bad read, bad or unknown command: straight to the result
//   read byte: one registered read of the store
//   plot: a read-modify-write of one byte on the store, only a flag off it
//   glyph byte: one pass per pixel, up to 8 pixels; each drawn pixel is a
//     read-modify-write of the store, a clipped one only sets status
//   clear: all DEPTH bytes, one byte written per cycle
// A new command can be taken while the previous result waits in the rsp
// register; if that register is still full when the next result is ready,
// the block holds the result and stays busy until rsp_ready.
// Reset: glyph state returns to its reset values and the store is zeroed by
// a pass over all DEPTH bytes (1024 here) during which req_ready stays low.
module page_framebuffer_plot_and_glyph_blit import pfb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CLEAR  = 3'd1;
	localparam logic [2:0] S_PIX_RD = 3'd2;
	localparam logic [2:0] S_PIX_WR = 3'd3;
	localparam logic [2:0] S_READ   = 3'd4;
	localparam logic [2:0] S_RDATA  = 3'd5;
	localparam logic [2:0] S_DONE   = 3'd6;

	logic [2:0]        state_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic              clr_cmd_q;    // clear came from a command, not reset
	logic [7:0]        plot_x_q;
	logic [7:0]        plot_y_q;
	logic              on_q;
	logic              glyph_q;      // pixel unit is working a glyph byte
	logic [7:0]        data_q;       // glyph bits, next pixel in bit 7
	logic [2:0]        bit_cnt_q;
	logic              status_q;
	logic [7:0]        rd_q;
	logic [ADDR_W-1:0] rd_addr_q;
	logic [7:0]        cursor_x_q;
	logic [7:0]        cursor_y_q;
	logic [7:0]        start_row_q;
	logic [4:0]        active_height_q;
	logic              glyph_mode_q;
	logic              glyph_active_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	logic              accept;
	logic              rsp_load;
	logic [7:0]        px;
	logic [7:0]        py;
	logic              pix_in;
	logic [7:0]        pix_page;
	logic [7:0]        pix_mask;
	logic [ADDR_W-1:0] pix_addr;
	logic              pix_val;
	logic              pix_step;
	logic [7:0]        next_y;
	logic              wrap;
	logic              rd_in;
	logic              height_ok;
	wr_t               wr;
	logic [ADDR_W-1:0] raddr;
	logic [7:0]        rdata;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// result moves into the rsp register once that register is free
	assign rsp_load  = (state_q == S_DONE) && (!rsp_valid_q || rsp_ready);

	// ---- shared pixel unit: one pixel per pass, plot or glyph ----
	assign px       = glyph_q ? cursor_x_q : plot_x_q;
	assign py       = glyph_q ? cursor_y_q : plot_y_q;
	assign pix_in   = ({1'b0, px} < 9'(COLUMNS)) && ({1'b0, py} < 9'(ROWS));
	assign pix_page = 8'(PAGES - 1) - {3'b000, py[7:3]};
	assign pix_mask = 8'h80 >> py[2:0];
	assign pix_addr = store_addr(px, pix_page);
	// glyph bit 1 draws the mode color, bit 0 its inverse
	assign pix_val  = glyph_q ? ~(data_q[7] ^ glyph_mode_q) : on_q;
	// a pixel finishes after its write, or at once when clipped
	assign pix_step = ((state_q == S_PIX_RD) && !pix_in) || (state_q == S_PIX_WR);

	// glyph cursor walk: down the column, wrap to the next column at height
	assign next_y = 8'(cursor_y_q + 8'd1);
	assign wrap   = (8'(next_y - start_row_q) == {3'b000, active_height_q});

	assign rd_in     = ({1'b0, req.x} < 9'(COLUMNS)) && ({1'b0, req.y} < 9'(PAGES));
	assign height_ok = (req.glyph_height == GLYPH_H12) ||
		(req.glyph_height == GLYPH_H16) || (req.glyph_height == GLYPH_H24);

	// store port: clear pass and pixel writes never overlap
	always_comb begin
		wr.en   = (state_q == S_CLEAR) || (state_q == S_PIX_WR);
		wr.addr = (state_q == S_CLEAR) ? clr_addr_q : pix_addr;
		wr.data = (state_q == S_CLEAR) ? 8'h00 :
			(pix_val ? (rdata | pix_mask) : (rdata & ~pix_mask));
		raddr   = (state_q == S_READ) ? rd_addr_q : pix_addr;
	end

	pfb_store u_store (
		.clk   (clk),
		.wr    (wr),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_CLEAR;
			clr_addr_q      <= '0;
			clr_cmd_q       <= 1'b0;
			plot_x_q        <= '0;
			plot_y_q        <= '0;
			on_q            <= 1'b0;
			glyph_q         <= 1'b0;
			data_q          <= '0;
			bit_cnt_q       <= '0;
			status_q        <= 1'b0;
			rd_q            <= '0;
			rd_addr_q       <= '0;
			cursor_x_q      <= '0;
			cursor_y_q      <= '0;
			start_row_q     <= '0;
			active_height_q <= '0;
			glyph_mode_q    <= 1'b1;
			glyph_active_q  <= 1'b0;
			rsp_q           <= '0;
			rsp_valid_q     <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						status_q <= 1'b0;
						rd_q     <= '0;
						unique case (req.cmd)
							CMD_PLOT: begin
								plot_x_q <= req.x;
								plot_y_q <= req.y;
								on_q     <= req.pixel_on;
								glyph_q  <= 1'b0;
								state_q  <= S_PIX_RD;
							end
							CMD_CLEAR: begin
								clr_addr_q <= '0;
								clr_cmd_q  <= 1'b1;
								state_q    <= S_CLEAR;
							end
							CMD_READ: begin
								rd_addr_q <= store_addr(req.x, req.y);
								if (rd_in) begin
									state_q <= S_READ;
								end else begin
									status_q <= 1'b1;
									state_q  <= S_DONE;
								end
							end
							CMD_GLYPH_START: begin
								cursor_x_q   <= req.x;
								cursor_y_q   <= req.y;
								start_row_q  <= req.y;
								glyph_mode_q <= req.pixel_on;
								if (height_ok) begin
									active_height_q <= req.glyph_height[4:0];
									glyph_active_q  <= 1'b1;
								end else begin
									active_height_q <= '0;
									glyph_active_q  <= 1'b0;
									status_q        <= 1'b1;
								end
								state_q <= S_DONE;
							end
							CMD_GLYPH_BYTE: begin
								if (glyph_active_q) begin
									data_q    <= req.data_byte;
									bit_cnt_q <= '0;
									glyph_q   <= 1'b1;
									state_q   <= S_PIX_RD;
								end else begin
									status_q <= 1'b1;
									state_q  <= S_DONE;
								end
							end
							default: begin
								status_q <= 1'b1;
								state_q  <= S_DONE;
							end
						endcase
					end
				end
				S_CLEAR: begin
					clr_addr_q <= ADDR_W'(clr_addr_q + 1'b1);
					if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
						clr_cmd_q <= 1'b0;
						state_q   <= clr_cmd_q ? S_DONE : S_IDLE;
					end
				end
				S_PIX_RD: begin
					// store read issued here; clipped pixels only flag
					if (pix_in) begin
						state_q <= S_PIX_WR;
					end else begin
						status_q <= 1'b1;
					end
				end
				S_PIX_WR: begin
					// modified byte goes out on the write port
				end
				S_READ: begin
					state_q <= S_RDATA;
				end
				S_RDATA: begin
					rd_q    <= rdata;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (rsp_load) begin
						rsp_q.read_byte <= rd_q;
						rsp_q.status    <= status_q;
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// end of one pixel pass: advance the glyph cursor or finish
			if (pix_step) begin
				if (!glyph_q) begin
					state_q <= S_DONE;
				end else begin
					data_q    <= {data_q[6:0], 1'b0};
					bit_cnt_q <= 3'(bit_cnt_q + 3'd1);
					if (wrap) begin
						// remaining bits of the byte are dropped
						cursor_y_q <= start_row_q;
						cursor_x_q <= 8'(cursor_x_q + 8'd1);
						state_q    <= S_DONE;
					end else begin
						cursor_y_q <= next_y;
						state_q    <= (bit_cnt_q == 3'd7) ? S_DONE : S_PIX_RD;
					end
				end
			end
		end
	end

endmodule

// ----- rtl/pfb_checker.sv -----
module pfb_checker import pfb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	logic       req_fire;
	logic       rsp_fire;
	logic [1:0] open_q;   // commands accepted whose beat is not yet taken

	assign req_fire = req_valid && req_ready;
	assign rsp_fire = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else begin
			open_q <= 2'(open_q + {1'b0, req_fire} - {1'b0, rsp_fire});
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("rsp beat dropped or changed while stalled");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> !req_ready)
		else $error("req_ready high right after a command was taken");

	a_clear_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !req_ready)
		else $error("req_ready high during the reset clear pass");

	a_rsp_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_fire |-> open_q != 2'd0)
		else $error("rsp beat without an open command");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |-> open_q == 2'd0 || open_q == 2'd1)
		else $error("command taken with two results still open");

endmodule

bind page_framebuffer_plot_and_glyph_blit pfb_checker u_pfb_checker (.*);

// ----- test/tb_page_framebuffer_plot_and_glyph_blit.sv -----
module tb_page_framebuffer_plot_and_glyph_blit import pfb_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	// Command codes the block has no use for: it answers them with status set.
	localparam logic [2:0] CMD_UNDEF_5 = 3'd5;
	localparam logic [2:0] CMD_UNDEF_7 = 3'd7;

	localparam logic ST_DONE = 1'b0;
	localparam logic ST_SKIP = 1'b1;

	// Directed rows either carry a response typed in by hand or defer to the predictor.
	localparam bit CHK_FIXED = 1'b1;
	localparam bit CHK_MODEL = 1'b0;

	localparam int TOTAL_BEATS = 750;
	localparam int LONG_HOLD   = 400;   // receiver hold-off, in cycles
	localparam int TAIL_CYCLES = 40;
	localparam int LIMIT_NS    = 4_000_000;
	localparam int DIR_N       = 24;

	typedef struct packed {
		req_t cmd;
		bit   chk;
		rsp_t want;
	} dir_row_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	page_framebuffer_plot_and_glyph_blit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor: a shadow of the frame store and the glyph cursor.
	// ------------------------------------------------------------------
	logic [7:0] shadow_fb [DEPTH];
	logic [7:0] pen_x;
	logic [7:0] pen_y;
	logic [7:0] glyph_top;
	logic [4:0] glyph_rows;
	logic       glyph_normal;
	logic       glyph_open;

	function automatic void shadow_reset();
		foreach (shadow_fb[i])
			shadow_fb[i] = 8'h00;
		pen_x        = 8'd0;
		pen_y        = 8'd0;
		glyph_top    = 8'd0;
		glyph_rows   = 5'd0;
		glyph_normal = 1'b1;
		glyph_open   = 1'b0;
	endfunction

	// Writes one pixel; returns 1 when it falls off the store.
	function automatic logic paint_pixel(input logic [7:0] px, input logic [7:0] py,
		input logic on);
		int         idx;
		logic [7:0] mask;
		if (px >= COLUMNS || py >= ROWS)
			return 1'b1;
		// row 0 sits in the last page, at the MSB
		idx  = int'(px) * PAGES + (PAGES - 1 - int'(py) / 8);
		mask = 8'h80 >> py[2:0];
		if (on)
			shadow_fb[idx] = shadow_fb[idx] | mask;
		else
			shadow_fb[idx] = shadow_fb[idx] & ~mask;
		return 1'b0;
	endfunction

	function automatic rsp_t frame_response(input req_t r);
		rsp_t       o;
		logic [7:0] drawn;
		o = '0;
		case (r.cmd)
			CMD_PLOT: begin
				o.status = paint_pixel(r.x, r.y, r.pixel_on);
			end
			CMD_CLEAR: begin
				// glyph cursor and mode survive a clear
				foreach (shadow_fb[i])
					shadow_fb[i] = 8'h00;
			end
			CMD_READ: begin
				if (r.x < COLUMNS && r.y < PAGES)
					o.read_byte = shadow_fb[int'(r.x) * PAGES + int'(r.y)];
				else
					o.status = ST_SKIP;
			end
			CMD_GLYPH_START: begin
				pen_x        = r.x;
				pen_y        = r.y;
				glyph_top    = r.y;
				glyph_normal = r.pixel_on;
				if (r.glyph_height == GLYPH_H12 || r.glyph_height == GLYPH_H16 ||
					r.glyph_height == GLYPH_H24) begin
					glyph_rows = r.glyph_height[4:0];
					glyph_open = 1'b1;
				end else begin
					glyph_rows = 5'd0;
					glyph_open = 1'b0;
					o.status   = ST_SKIP;
				end
			end
			CMD_GLYPH_BYTE: begin
				if (!glyph_open) begin
					o.status = ST_SKIP;
				end else begin
					for (int b = 7; b >= 0; b--) begin
						// inverted mode paints the zero bits
						if (paint_pixel(pen_x, pen_y, r.data_byte[b] ~^ glyph_normal))
							o.status = ST_SKIP;
						pen_y = pen_y + 8'd1;
						drawn = pen_y - glyph_top;
						if (drawn == {3'b000, glyph_rows}) begin
							// column full: next column, rest of the byte is dropped
							pen_y = glyph_top;
							pen_x = pen_x + 8'd1;
							break;
						end
					end
				end
			end
			default: begin
				o.status = ST_SKIP;
			end
		endcase
		return o;
	endfunction

	// ------------------------------------------------------------------
	// Scoreboard state
	// ------------------------------------------------------------------
	rsp_t want_rsp_q [$];
	int   fail_cnt    = 0;
	int   rsp_seen    = 0;
	int   flagged_cnt = 0;
	int   beats_sent  = 0;
	int   cmd_hits [8];
	int   burst_left  = 0;

	// Toggled by the stimulus to ask the receiver for a long hold-off.
	logic hold_tgl  = 1'b0;
	logic hold_seen = 1'b0;

	// ------------------------------------------------------------------
	// Directed table. Row fields: cmd, x, y, pixel_on, height, data,
	// check kind, read_byte, status.
	// ------------------------------------------------------------------
	dir_row_t dir_tab [DIR_N] = '{
		// store reads back zero after the reset clearing pass, both corners
		{CMD_READ,        8'd0,   8'd0,   1'b0, 8'd0,   8'h00, CHK_FIXED, 8'h00, ST_DONE},
		{CMD_READ,        8'd127, 8'd7,   1'b1, 8'd255, 8'hff, CHK_FIXED, 8'h00, ST_DONE},
		// reads off the store: column past the edge, page past the edge
		{CMD_READ,        8'd128, 8'd0,   1'b0, 8'd0,   8'h00, CHK_FIXED, 8'h00, ST_SKIP},
		{CMD_READ,        8'd0,   8'd8,   1'b0, 8'd0,   8'h00, CHK_FIXED, 8'h00, ST_SKIP},
		// top-left pixel lands in the last page, MSB
		{CMD_PLOT,        8'd0,   8'd0,   1'b1, 8'd0,   8'h00, CHK_FIXED, 8'h00, ST_DONE},
		{CMD_READ,        8'd0,   8'd7,   1'b0, 8'd0,   8'h00, CHK_FIXED, 8'h80, ST_DONE},
		// bottom-right pixel lands in page 0, LSB
		{CMD_PLOT,        8'd127, 8'd63,  1'b1, 8'd0,   8'h00, CHK_FIXED, 8'h00, ST_DONE},
		{CMD_READ,        8'd127, 8'd0,   1'b0, 8'd0,   8'h00, CHK_FIXED, 8'h01, ST_DONE},
		// plots off the store, then the top-left pixel cleared again
		{CMD_PLOT,        8'd128, 8'd0,   1'b1, 8'd0,   8'h00, CHK_FIXED, 8'h00, ST_SKIP},
		{CMD_PLOT,        8'd255, 8'd255, 1'b1, 8'd0,   8'h00, CHK_FIXED, 8'h00, ST_SKIP},
		{CMD_PLOT,        8'd0,   8'd0,   1'b0, 8'd0,   8'h00, CHK_FIXED, 8'h00, ST_DONE},
		// undefined opcode
		{CMD_UNDEF_7,     8'd255, 8'd255, 1'b1, 8'd255, 8'hff, CHK_FIXED, 8'h00, ST_SKIP},
		// glyph byte with nothing open
		{CMD_GLYPH_BYTE,  8'd0,   8'd0,   1'b1, 8'd0,   8'hff, CHK_FIXED, 8'h00, ST_SKIP},
		// bad height closes the glyph, the next byte is refused
		{CMD_GLYPH_START, 8'd10,  8'd20,  1'b1, 8'd255, 8'h00, CHK_FIXED, 8'h00, ST_SKIP},
		{CMD_GLYPH_BYTE,  8'd0,   8'd0,   1'b1, 8'd0,   8'hff, CHK_FIXED, 8'h00, ST_SKIP},
		// glyph running off the bottom edge: partly clipped
		{CMD_GLYPH_START, 8'd10,  8'd60,  1'b1, 8'd12,  8'h00, CHK_FIXED, 8'h00, ST_DONE},
		{CMD_GLYPH_BYTE,  8'd0,   8'd0,   1'b0, 8'd0,   8'ha5, CHK_MODEL, 8'h00, ST_DONE},
		// inverted glyph from x = 255, off the store, rows wrapping past 255; the column
		// wraps to 0 after twelve rows, where the wrapped rows land in the store
		{CMD_GLYPH_START, 8'd255, 8'd250, 1'b0, 8'd12,  8'h00, CHK_FIXED, 8'h00, ST_DONE},
		{CMD_GLYPH_BYTE,  8'd0,   8'd0,   1'b0, 8'd0,   8'hff, CHK_MODEL, 8'h00, ST_DONE},
		{CMD_GLYPH_BYTE,  8'd0,   8'd0,   1'b0, 8'd0,   8'h0f, CHK_MODEL, 8'h00, ST_DONE},
		{CMD_GLYPH_BYTE,  8'd0,   8'd0,   1'b0, 8'd0,   8'h81, CHK_MODEL, 8'h00, ST_DONE},
		{CMD_READ,        8'd0,   8'd7,   1'b0, 8'd0,   8'h00, CHK_MODEL, 8'h00, ST_DONE},
		// clear wipes everything
		{CMD_CLEAR,       8'd0,   8'd0,   1'b0, 8'd0,   8'h00, CHK_FIXED, 8'h00, ST_DONE},
		{CMD_READ,        8'd0,   8'd7,   1'b0, 8'd0,   8'h00, CHK_FIXED, 8'h00, ST_DONE}
	};

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------
	function automatic req_t rand_req();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[$bits(req_t)-1:0];
	endfunction

	// Called right after a rising edge. Opens a random gap at the end of a
	// burst, then offers the beat and waits for it to be taken. Valid stays
	// high on return so back-to-back beats never drop it.
	task automatic send_beat(input req_t r, input bit chk, input rsp_t want);
		int   gap;
		rsp_t pred;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) == 0)
				gap = 0;
			else if ($urandom_range(0, 7) == 0)
				gap = $urandom_range(5, 40);
			else
				gap = $urandom_range(1, 4);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		// beat taken at this edge
		pred = frame_response(r);
		want_rsp_q.push_back(chk == CHK_FIXED ? want : pred);
		cmd_hits[r.cmd]++;
		if (r.cmd <= CMD_GLYPH_BYTE)
			beats_sent++;
	endtask

	// Drop valid and wait until every response has come back.
	task automatic pause_for_drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (want_rsp_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] pick_coord(input int span);
		// mostly on the store, now and then anywhere in the field
		if ($urandom_range(0, 6) == 0)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(0, span - 1));
	endfunction

	initial begin
		req_t rq;
		int   pick;
		int   n;
		bit   hold_done;
		bit   pause_done;
		hold_done  = 1'b0;
		pause_done = 1'b0;
		foreach (cmd_hits[i])
			cmd_hits[i] = 0;
		shadow_reset();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		for (int i = 0; i < DIR_N; i++)
			send_beat(dir_tab[i].cmd, dir_tab[i].chk, dir_tab[i].want);
		pause_for_drain();

		// random part: mostly plots, reads and well-formed glyph runs
		while (beats_sent < TOTAL_BEATS) begin
			if (!hold_done && beats_sent >= 250) begin
				// receiver holds off while we keep offering back to back
				hold_tgl  <= ~hold_tgl;
				hold_done  = 1'b1;
				burst_left = 48;
			end
			if (!pause_done && beats_sent >= 500) begin
				pause_for_drain();
				pause_done = 1'b1;
			end
			pick = $urandom_range(0, 99);
			rq   = rand_req();
			if (pick < 40) begin
				rq.cmd = CMD_GLYPH_START;
				rq.x   = pick_coord(COLUMNS);
				rq.y   = pick_coord(ROWS);
				case ($urandom_range(0, 9))
					0:       rq.glyph_height = 8'($urandom_range(0, 255));
					1, 2, 3: rq.glyph_height = GLYPH_H12;
					4, 5, 6: rq.glyph_height = GLYPH_H16;
					default: rq.glyph_height = GLYPH_H24;
				endcase
				send_beat(rq, CHK_MODEL, '0);
				n = $urandom_range(1, 10);
				repeat (n) begin
					rq     = rand_req();
					rq.cmd = CMD_GLYPH_BYTE;
					send_beat(rq, CHK_MODEL, '0);
				end
			end else if (pick < 65) begin
				rq.cmd = CMD_PLOT;
				rq.x   = pick_coord(COLUMNS);
				rq.y   = pick_coord(ROWS);
				send_beat(rq, CHK_MODEL, '0);
			end else if (pick < 90) begin
				rq.cmd = CMD_READ;
				rq.x   = pick_coord(COLUMNS);
				rq.y   = pick_coord(PAGES);
				send_beat(rq, CHK_MODEL, '0);
			end else if (pick < 91) begin
				rq.cmd = CMD_CLEAR;
				send_beat(rq, CHK_MODEL, '0);
			end else if (pick < 94) begin
				rq.cmd = 3'($urandom_range(CMD_UNDEF_5, CMD_UNDEF_7));
				send_beat(rq, CHK_MODEL, '0);
			end else begin
				// loose noise; clears stay rare since each one walks the store
				if (rq.cmd == CMD_CLEAR)
					rq.cmd = CMD_GLYPH_BYTE;
				send_beat(rq, CHK_MODEL, '0);
			end
		end

		pause_for_drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("run covered %0d beats: plot %0d, clear %0d, read %0d, glyph start %0d, %s %0d",
			beats_sent + cmd_hits[5] + cmd_hits[6] + cmd_hits[7], cmd_hits[CMD_PLOT],
			cmd_hits[CMD_CLEAR], cmd_hits[CMD_READ], cmd_hits[CMD_GLYPH_START],
			"glyph byte", cmd_hits[CMD_GLYPH_BYTE]);
		$display("undefined %0d; %0d responses checked, %0d ignored or clipped, %0d mismatches",
			cmd_hits[5] + cmd_hits[6] + cmd_hits[7], rsp_seen, flagged_cnt, fail_cnt);
		if (fail_cnt == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// ------------------------------------------------------------------
	// Receiver: stall patterns picked at random for random spans, plus a
	// long hold-off on request, counted here in cycles.
	// ------------------------------------------------------------------
	initial begin
		int mode;
		int span_left;
		int hold_left;
		mode      = 0;
		span_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_tgl != hold_seen) begin
				hold_seen = hold_tgl;
				hold_left = LONG_HOLD;
			end
			if (span_left == 0) begin
				mode      = $urandom_range(0, 3);
				span_left = $urandom_range(16, 160);
			end
			span_left--;
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				case (mode)
					0:       rsp_ready <= 1'b1;                          // no stalls
					1:       rsp_ready <= ($urandom_range(0, 3) != 0);   // light
					2:       rsp_ready <= ($urandom_range(0, 3) == 0);   // heavy
					default: rsp_ready <= ~rsp_ready;                    // alternating
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Response checker: each beat against the oldest expectation.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		rsp_t exp_rsp;
		if (arst_n && rsp_valid && rsp_ready) begin
			rsp_seen++;
			if (want_rsp_q.size() == 0) begin
				fail_cnt++;
				$display("%0t: response beat with none expected: read_byte %02h status %0b",
					$time, rsp.read_byte, rsp.status);
			end else begin
				exp_rsp = want_rsp_q.pop_front();
				if (exp_rsp.status)
					flagged_cnt++;
				if (rsp.read_byte !== exp_rsp.read_byte) begin
					fail_cnt++;
					$display("%0t: read_byte expected %02h got %02h",
						$time, exp_rsp.read_byte, rsp.read_byte);
				end
				if (rsp.status !== exp_rsp.status) begin
					fail_cnt++;
					$display("%0t: status expected %0b got %0b",
						$time, exp_rsp.status, rsp.status);
				end
			end
		end
	end

	// Watchdog
	initial begin
		#(LIMIT_NS);
		$display("tb: failure");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/pfb_pkg.sv
rtl/pfb_store.sv
rtl/page_framebuffer_plot_and_glyph_blit.sv
rtl/pfb_checker.sv
test/tb_page_framebuffer_plot_and_glyph_blit.sv
